[hdl/cws_pkg.sv]
// cws_pkg: shared types and constants for the command word substituter
// no dependencies; imported by cws_store, cws_walk and command_word_substituter
package cws_pkg;

	localparam int ENTRIES_DEF   = 32;
	localparam int NUM_BANKS_DEF = 8;

	localparam logic [7:0] END_LIST_OP = 8'hB8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	localparam logic REG_TABLE_SELECT = 1'b0;
	localparam logic REG_END_MODE     = 1'b1;

	localparam int WORD_W  = 64;
	localparam int MATCH_W = 6;
	localparam int TOTAL_W = 32;
	localparam int SEL_W   = 3;
	localparam int ENTRY_W = 5;

	localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              is_last;
	} cws_req_t;

	typedef struct packed {
		logic               valid;
		logic [WORD_W-1:0]  word;
		logic [MATCH_W-1:0] match_cnt;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} cws_result_t;

endpackage

[hdl/cws_store.sv]
// cws_store: search and replace pair memories, one write port, one registered read port
// depends on cws_pkg
module cws_store #(
	parameter int DEPTH = cws_pkg::ENTRIES_DEF * cws_pkg::NUM_BANKS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [cws_pkg::WORD_W-1:0]  wr_search,
	input  logic [cws_pkg::WORD_W-1:0]  wr_replace,
	input  logic [AW-1:0]               rd_addr,
	output logic [cws_pkg::WORD_W-1:0]  rd_search,
	output logic [cws_pkg::WORD_W-1:0]  rd_replace
);
	import cws_pkg::*;

	logic [WORD_W-1:0] search_mem  [DEPTH];
	logic [WORD_W-1:0] replace_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			search_mem[wr_addr]  <= wr_search;
			replace_mem[wr_addr] <= wr_replace;
		end
	end

	always_ff @(posedge clk) begin
		rd_search  <= search_mem[rd_addr];
		rd_replace <= replace_mem[rd_addr];
	end

endmodule

[hdl/cws_walk.sv]
// cws_walk: sequencer that walks one bank entry per cycle through a shared compare unit
// depends on cws_pkg; reads pairs from cws_store
module cws_walk #(
	parameter int ENTRIES   = cws_pkg::ENTRIES_DEF,
	parameter int NUM_BANKS = cws_pkg::NUM_BANKS_DEF,
	parameter int AW        = (ENTRIES * NUM_BANKS > 1) ? $clog2(ENTRIES * NUM_BANKS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  cws_pkg::cws_req_t           req,
	input  logic [cws_pkg::SEL_W-1:0]   table_select,
	input  logic                        end_mode,
	output logic                        idle,
	output logic [AW-1:0]               rd_addr,
	input  logic [cws_pkg::WORD_W-1:0]  rd_search,
	input  logic [cws_pkg::WORD_W-1:0]  rd_replace,
	input  logic                        out_free,
	output cws_pkg::cws_result_t        result
);
	import cws_pkg::*;

	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

	state_t             state_q;
	logic [WORD_W-1:0]  word_q;
	logic [MATCH_W-1:0] matches_q;
	logic [TOTAL_W-1:0] total_q;
	logic               last_q;
	logic [EW-1:0]      e_q;
	logic [AW-1:0]      addr_q;

	logic          is_term;
	logic          last_in;
	logic          bank_ok;
	logic [AW-1:0] base;
	logic          hit;
	logic          stop;
	logic          last_entry;

	assign is_term    = end_mode && (req.word[WORD_W-1 -: 8] == END_LIST_OP);
	assign last_in    = end_mode ? is_term : req.is_last;
	assign bank_ok    = 32'(table_select) < NUM_BANKS;
	assign base       = AW'(32'(table_select) * ENTRIES);
	assign rd_addr    = (state_q == ST_IDLE) ? base : addr_q + AW'(1);
	assign hit        = rd_search == word_q;
	assign stop       = rd_search[WORD_W-1:WORD_W/2] == '0;
	assign last_entry = e_q == EW'(ENTRIES - 1);
	assign idle       = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			word_q    <= '0;
			matches_q <= '0;
			total_q   <= '0;
			last_q    <= 1'b0;
			e_q       <= '0;
			addr_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						word_q    <= req.word;
						last_q    <= last_in;
						matches_q <= '0;
						e_q       <= '0;
						addr_q    <= rd_addr;
						state_q   <= (is_term || !bank_ok) ? ST_DONE : ST_WALK;
					end
				end
				ST_WALK: begin
					if (stop) begin
						state_q <= ST_DONE;
					end else begin
						if (hit) begin
							word_q  <= rd_replace;
							total_q <= total_q + TOTAL_W'(1);
							if (matches_q != MATCH_MAX) begin
								matches_q <= matches_q + MATCH_W'(1);
							end
						end
						if (last_entry) begin
							state_q <= ST_DONE;
						end else begin
							e_q    <= e_q + EW'(1);
							addr_q <= rd_addr;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		result.valid     = state_q == ST_DONE;
		result.word      = word_q;
		result.match_cnt = matches_q;
		result.total     = total_q;
		result.last      = last_q;
	end

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("start outside idle");

	a_matches_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> 32'(matches_q) <= 32'(e_q))
		else $error("more matches than entries compared");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && !stop && hit) |=> total_q == $past(total_q) + TOTAL_W'(1))
		else $error("running total missed a replacement");

	a_total_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_WALK |=> $stable(total_q))
		else $error("running total changed outside walk");
`endif

endmodule

[hdl/command_word_substituter.sv]
// command_word_substituter: rewrites 64-bit command words through banks of search/replace pairs
// load transfer: writes one pair; command transfer: walk of n <= ENTRIES pairs, one per cycle
// an accepted command walks its bank, then waits in ST_DONE until the output register is free;
// a terminator or out-of-range bank skips the walk; s_tready is low until the walk is idle again
// arst_n clears config, running total and handshake state; pair tables are undefined until loaded
// depends on cws_pkg, cws_store, cws_walk
module command_word_substituter #(
	parameter int ENTRIES   = cws_pkg::ENTRIES_DEF,
	parameter int NUM_BANKS = cws_pkg::NUM_BANKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// bank_index[2:0], entry_index[7:3], search_word[71:8], replace_word[135:72],
	// command_word[199:136]
	input  logic [199:0]  s_tdata,
	// opcode
	input  logic [0:0]    s_tuser,
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	// out_word[63:0], match_count[69:64], total_count[101:70], zero pad[103:102]
	output logic [103:0]  m_tdata,
	output logic          m_tlast,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import cws_pkg::*;

	localparam int DEPTH = ENTRIES * NUM_BANKS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [SEL_W-1:0] table_select_q;
	logic             end_mode_q;

	logic [SEL_W-1:0]   in_bank;
	logic [ENTRY_W-1:0] in_entry;
	logic [WORD_W-1:0]  in_search;
	logic [WORD_W-1:0]  in_replace;
	logic [WORD_W-1:0]  in_command;
	logic               in_accept;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [WORD_W-1:0] rd_search;
	logic [WORD_W-1:0] rd_replace;

	logic        walk_idle;
	logic        start;
	cws_req_t    req;
	cws_result_t result;
	logic        out_free;
	logic        out_push;

	logic               m_tvalid_q;
	logic [WORD_W-1:0]  out_word_q;
	logic [MATCH_W-1:0] out_matches_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_last_q;

	assign in_bank    = s_tdata[2:0];
	assign in_entry   = s_tdata[7:3];
	assign in_search  = s_tdata[71:8];
	assign in_replace = s_tdata[135:72];
	assign in_command = s_tdata[199:136];

	assign s_tready  = walk_idle;
	assign in_accept = s_tvalid && s_tready;

	assign wr_en   = in_accept && (s_tuser[0] == OP_LOAD)
		&& (32'(in_bank) < NUM_BANKS) && (32'(in_entry) < ENTRIES);
	assign wr_addr = AW'(32'(in_bank) * ENTRIES + 32'(in_entry));

	assign start       = in_accept && (s_tuser[0] == OP_CMD);
	assign req.word    = in_command;
	assign req.is_last = s_tlast;

	// apb register file
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_END_MODE) ? {31'b0, end_mode_q} : {29'b0, table_select_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_select_q <= '0;
			end_mode_q     <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_TABLE_SELECT: table_select_q <= pwdata[SEL_W-1:0];
				REG_END_MODE:     end_mode_q     <= pwdata[0];
				default:          table_select_q <= table_select_q;
			endcase
		end
	end

	cws_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_search  (in_search),
		.wr_replace (in_replace),
		.rd_addr    (rd_addr),
		.rd_search  (rd_search),
		.rd_replace (rd_replace)
	);

	cws_walk #(
		.ENTRIES   (ENTRIES),
		.NUM_BANKS (NUM_BANKS),
		.AW        (AW)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (req),
		.table_select (table_select_q),
		.end_mode     (end_mode_q),
		.idle         (walk_idle),
		.rd_addr      (rd_addr),
		.rd_search    (rd_search),
		.rd_replace   (rd_replace),
		.out_free     (out_free),
		.result       (result)
	);

	// output register
	assign out_free = !m_tvalid_q || m_tready;
	assign out_push = result.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_word_q    <= result.word;
			out_matches_q <= result.match_cnt;
			out_total_q   <= result.total;
			out_last_q    <= result.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_total_q, out_matches_q, out_word_q};
	assign m_tlast  = out_last_q;

endmodule
